// ----- rtl/urrb_pkg.sv -----
package urrb_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned RING_CFG_W = 9;

  localparam logic [FUNC_W-1:0] FN_RX    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_OVF   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_data;
    logic [LEN_W-1:0]  count;
    logic              overflowed;
    logic              last;
  } res_t;

  // result handed from the sequencer to the output queue
  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  // output queue status seen by the sequencer
  typedef struct packed {
    logic [1:0] occ;
    logic       pop;
  } qstat_t;

endpackage

// ----- rtl/urrb_in_if.sv -----
interface urrb_in_if;
  logic                           valid;
  logic                           ready;
  logic [urrb_pkg::FUNC_W-1:0]    func;
  logic [urrb_pkg::BYTE_W-1:0]    rx_data;
  logic                           rx_overrun;
  logic [urrb_pkg::LEN_W-1:0]     read_len;

  modport source (output valid, func, rx_data, rx_overrun, read_len, input ready);
  modport sink (input valid, func, rx_data, rx_overrun, read_len, output ready);
endinterface

// ----- rtl/urrb_out_if.sv -----
interface urrb_out_if;
  logic                         valid;
  logic                         ready;
  logic [urrb_pkg::BYTE_W-1:0]  data;
  logic                         has_data;
  logic [urrb_pkg::LEN_W-1:0]   count;
  logic                         overflowed;
  logic                         last;

  modport source (output valid, data, has_data, count, overflowed, last, input ready);
  modport sink (input valid, data, has_data, count, overflowed, last, output ready);
endinterface

// ----- rtl/urrb_cfg_if.sv -----
interface urrb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [urrb_pkg::RING_CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/uart_rx_ring_buffer.sv -----
// Receive FIFO behind a serial port, one ring of DEPTH bytes in a synchronous RAM.
// in_ch carries one command per transfer: store a received byte, read up to read_len
// bytes, take the sticky overflow flag, or clear. cfg_ch writes ring_size, which also
// empties the ring and clears the flag; it is taken only while in_ch is ready.
// A store, a clear and a config write are done without leaving ST_IDLE. A read pops one
// byte per cycle through the RAM read port while the queue has credit; the first byte
// passes the state register, the RAM read register and the queue before it shows on
// out_ch, and in_ch is ready again once the last fetched byte has been pushed. A read of
// nothing and an overflow query give one result through ST_RESP once the queue has room.
// Every command result ends with last set.
// out_ch sits behind a two-entry queue; the fetch loop stalls on its credit when
// out_ch.ready is low, so nothing is lost and the command side waits for the read.
// After reset the ring is empty, the flag is clear and ring_size is DEPTH. The RAM
// is not cleared: only bytes that were stored are ever read.
module uart_rx_ring_buffer #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input logic         clk,
  input logic         rst_n,
  urrb_in_if.sink     in_ch,
  urrb_cfg_if.sink    cfg_ch,
  urrb_out_if.source  out_ch
);

  urrb_pkg::push_t              push;
  urrb_pkg::qstat_t             qstat;
  logic                         mem_we;
  logic [$clog2(DEPTH)-1:0]     mem_waddr;
  logic [urrb_pkg::BYTE_W-1:0]  mem_wdata;
  logic                         mem_re;
  logic [$clog2(DEPTH)-1:0]     mem_raddr;
  logic [urrb_pkg::BYTE_W-1:0]  mem_rdata;

  urrb_ctrl #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .qstat     (qstat),
    .push      (push),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  urrb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  urrb_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .qstat  (qstat),
    .out_ch (out_ch)
  );

endmodule

// ----- rtl/urrb_ram.sv -----
module urrb_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [urrb_pkg::BYTE_W-1:0]   wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [urrb_pkg::BYTE_W-1:0]   rdata
);

  logic [urrb_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [urrb_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/urrb_outq.sv -----
module urrb_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  urrb_pkg::push_t      push,
  output urrb_pkg::qstat_t     qstat,
  urrb_out_if.source           out_ch
);

  urrb_pkg::res_t q_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     occ_r;
  logic [1:0]     occ_nxt;
  logic           pop;

  assign pop     = out_ch.valid & out_ch.ready;
  assign occ_nxt = occ_r + {1'b0, push.valid} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      occ_r <= 2'd0;
    end else begin
      occ_r <= occ_nxt;
      if (push.valid) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_r[wp_r] <= push.res;
    end
  end

  assign out_ch.valid      = (occ_r != 2'd0);
  assign out_ch.data       = q_r[rp_r].data;
  assign out_ch.has_data   = q_r[rp_r].has_data;
  assign out_ch.count      = q_r[rp_r].count;
  assign out_ch.overflowed = q_r[rp_r].overflowed;
  assign out_ch.last       = q_r[rp_r].last;

  assign qstat.occ = occ_r;
  assign qstat.pop = pop;

endmodule

// ----- rtl/urrb_ctrl.sv -----
module urrb_ctrl #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  urrb_in_if.sink                       in_ch,
  urrb_cfg_if.sink                      cfg_ch,
  input  urrb_pkg::qstat_t              qstat,
  output urrb_pkg::push_t               push,
  output logic                          mem_we,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr,
  output logic [urrb_pkg::BYTE_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr,
  input  logic [urrb_pkg::BYTE_W-1:0]   mem_rdata
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = (IW + 1 > urrb_pkg::RING_CFG_W) ? IW + 1 : urrb_pkg::RING_CFG_W;
  localparam int unsigned LW = urrb_pkg::LEN_W;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RESP} state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]   last_r, last_nxt;
  logic            ovf_r, ovf_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  logic [LW-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic            pend_last_r, pend_last_nxt;
  logic            resp_ovf_r, resp_ovf_nxt;

  logic            in_ready;
  logic            in_acc;
  logic            cfg_acc;
  logic            can_issue;
  logic [IW-1:0]   rd_adv;
  logic [IW-1:0]   wr_adv;
  logic [LW-1:0]   cnt_inc;
  logic [LW-1:0]   len_clip;
  logic [CW-1:0]   rs;
  logic [CW-1:0]   rs_clamp;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] i, input logic [IW-1:0] lst);
    return (i == lst) ? '0 : i + 1'b1;
  endfunction

  assign in_ready     = (state_r == ST_IDLE) && !pend_r;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = in_ready;
  assign in_acc       = in_ch.valid & in_ready;
  assign cfg_acc      = cfg_ch.valid & in_ready;

  assign rd_adv   = adv(rd_idx_r, last_r);
  assign wr_adv   = adv(wr_idx_r, last_r);
  assign cnt_inc  = cnt_r + 1'b1;
  assign len_clip = (in_ch.read_len > LW'(MAX_READ)) ? LW'(MAX_READ) : in_ch.read_len;

  // credit check: queue slots plus the fetch in flight, a pop frees one
  assign can_issue = (state_r == ST_READ)
                     && (((qstat.occ + {1'b0, pend_r}) < 2'd2) || qstat.pop);

  always_comb begin
    rs = CW'(cfg_ch.data);
    if (rs < CW'(2)) begin
      rs_clamp = CW'(2);
    end else if (rs > CW'(DEPTH)) begin
      rs_clamp = CW'(DEPTH);
    end else begin
      rs_clamp = rs;
    end
  end

  assign mem_waddr = wr_idx_r;
  assign mem_wdata = in_ch.rx_data;
  assign mem_raddr = rd_idx_r;
  assign mem_re    = can_issue;

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_cnt_nxt  = pend_cnt_r;
    pend_last_nxt = pend_last_r;
    resp_ovf_nxt  = resp_ovf_r;
    mem_we        = 1'b0;
    push.valid    = 1'b0;
    push.res      = '0;

    // fetched byte lands in the cycle after its read
    if (pend_r) begin
      push.valid        = 1'b1;
      push.res.data     = mem_rdata;
      push.res.has_data = 1'b1;
      push.res.count    = pend_cnt_r;
      push.res.last     = pend_last_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.func)
            urrb_pkg::FN_RX: begin
              if (in_ch.rx_overrun || (wr_adv == rd_idx_r)) begin
                ovf_nxt = 1'b1;
              end else begin
                mem_we     = 1'b1;
                wr_idx_nxt = wr_adv;
              end
            end
            urrb_pkg::FN_READ: begin
              if ((len_clip == '0) || (rd_idx_r == wr_idx_r)) begin
                resp_ovf_nxt = 1'b0;
                state_nxt    = ST_RESP;
              end else begin
                len_nxt   = len_clip;
                cnt_nxt   = '0;
                state_nxt = ST_READ;
              end
            end
            urrb_pkg::FN_OVF: begin
              resp_ovf_nxt = ovf_r;
              ovf_nxt      = 1'b0;
              state_nxt    = ST_RESP;
            end
            urrb_pkg::FN_CLEAR: begin
              wr_idx_nxt = '0;
              rd_idx_nxt = '0;
              ovf_nxt    = 1'b0;
            end
            default: begin
              ovf_nxt = ovf_r;
            end
          endcase
        end
        if (cfg_acc) begin
          last_nxt   = IW'(rs_clamp - CW'(1));
          wr_idx_nxt = '0;
          rd_idx_nxt = '0;
          ovf_nxt    = 1'b0;
        end
      end
      ST_READ: begin
        if (can_issue) begin
          rd_idx_nxt    = rd_adv;
          cnt_nxt       = cnt_inc;
          pend_nxt      = 1'b1;
          pend_cnt_nxt  = cnt_inc;
          pend_last_nxt = (cnt_inc == len_r) || (rd_adv == wr_idx_r);
          if (pend_last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RESP: begin
        if (!pend_r && (qstat.occ < 2'd2)) begin
          push.valid          = 1'b1;
          push.res.overflowed = resp_ovf_r;
          push.res.last       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      last_r      <= IW'(DEPTH - 1);
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      last_r      <= last_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    cnt_r       <= cnt_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    pend_last_r <= pend_last_nxt;
    resp_ovf_r  <= resp_ovf_nxt;
  end

endmodule
